>>> sv/pts_pkg.sv
// Shared types, codes and helper functions for the periodic timer slot table.
package pts_pkg;

    // Request kind codes as they arrive on the request channel.
    localparam logic [2:0] KIND_CLAIM_FIRST = 3'd0;
    localparam logic [2:0] KIND_OVERWRITE   = 3'd1;
    localparam logic [2:0] KIND_CLAIM_IDLE  = 3'd2;
    localparam logic [2:0] KIND_FREE        = 3'd3;
    localparam logic [2:0] KIND_TICK        = 3'd4;
    localparam logic [2:0] KIND_FIRE        = 3'd5;
    localparam logic [2:0] KIND_FREE_ALL    = 3'd6;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Classified operation handed from the front part to the back part.
    typedef enum logic [2:0] {
        OP_CLAIM_FIRST,
        OP_OVERWRITE,
        OP_CLAIM_IDLE,
        OP_FREE,
        OP_TICK,
        OP_FIRE,
        OP_FREE_ALL,
        OP_FAIL
    } op_t;

    // One queued command.
    typedef struct packed {
        op_t         op;
        logic [7:0]  slot;
        logic [15:0] period;
        logic [7:0]  tick;
        logic [15:0] tag;
        logic [31:0] arg;
    } cmd_t;

    // One entry of the slot memory.
    typedef struct packed {
        logic [15:0] period;
        logic [16:0] elapsed;
        logic [15:0] tag;
        logic [31:0] arg;
    } slot_entry_t;

    // One result transaction.
    typedef struct packed {
        logic        status;
        logic [5:0]  slot;
        logic        fired;
        logic [15:0] tag;
        logic [31:0] arg;
        logic        last;
    } result_t;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_CLAIM,
        B_SCAN,
        B_DONE
    } back_state_t;

    // A successful single result with nothing fired.
    localparam result_t RES_OK = '{status: 1'b0, slot: 6'd0, fired: 1'b0,
                                   tag: 16'd0, arg: 32'd0, last: 1'b1};

    // Build a freshly loaded slot entry from a command.
    function automatic slot_entry_t make_entry(input cmd_t cmd);
        slot_entry_t e;
        e.period  = cmd.period;
        e.elapsed = 17'd0;
        e.tag     = cmd.tag;
        e.arg     = cmd.arg;
        return e;
    endfunction

endpackage

>>> sv/pts_req_if.sv
// Request channel interface of the periodic timer slot table.
interface pts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  slot_index;
    logic [15:0] period;
    logic [7:0]  tick_amount;
    logic [15:0] callback_tag;
    logic [31:0] callback_argument;

    modport source (
        output valid, kind, slot_index, period, tick_amount, callback_tag,
               callback_argument,
        input  ready
    );

    modport sink (
        input  valid, kind, slot_index, period, tick_amount, callback_tag,
               callback_argument,
        output ready
    );
endinterface

>>> sv/pts_rsp_if.sv
// Result channel interface of the periodic timer slot table.
interface pts_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [5:0]  result_slot;
    logic        fired;
    logic [15:0] fired_tag;
    logic [31:0] fired_argument;
    logic        last;

    modport source (
        output valid, status, result_slot, fired, fired_tag, fired_argument, last,
        input  ready
    );

    modport sink (
        input  valid, status, result_slot, fired, fired_tag, fired_argument, last,
        output ready
    );
endinterface

>>> sv/periodic_timer_slot_table_unit.sv
// Top level of the periodic timer slot table: front, command queue and back.
// A request passes the front register and a queue entry before the back part takes it;
// single-slot requests then give their result through the output register, while
// claim-first-idle, tick and fire walk the slot memory one slot per cycle, a fire walk
// holding while a report waits on the result channel. The back part runs one request at
// a time, set by the slot memory walk; the front and a two-entry queue accept meanwhile.
// Reset clears all busy flags and all handshake state; slot contents need no clearing.
module periodic_timer_slot_table_unit
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    pts_req_if.sink   req,
    pts_rsp_if.source rsp
);

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    // Request intake and classification.
    pts_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Command queue between the two parts.
    pts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Command execution and result output.
    pts_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

>>> sv/pts_front.sv
// Front part: accepts request transactions and classifies them into commands.
module pts_front
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    pts_req_if.sink   req,
    output logic      push_valid,
    input  logic      push_ready,
    output cmd_t      push_data
);

    logic fv_reg;
    logic fv_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic idx_ok;

    // The stage takes a new transaction whenever it is empty or draining.
    assign req.ready = !fv_reg || push_ready;
    assign accept    = req.valid && req.ready;
    assign idx_ok    = {1'b0, req.slot_index} < 9'(NUM_SLOTS);

    // Classify the request; slot-targeted kinds with a bad index fail here.
    always_comb
    begin
        cmd_next.slot   = req.slot_index;
        cmd_next.period = req.period;
        cmd_next.tick   = req.tick_amount;
        cmd_next.tag    = req.callback_tag;
        cmd_next.arg    = req.callback_argument;
        case (req.kind)
            KIND_CLAIM_FIRST: cmd_next.op = OP_CLAIM_FIRST;
            KIND_OVERWRITE:   cmd_next.op = idx_ok ? OP_OVERWRITE : OP_FAIL;
            KIND_CLAIM_IDLE:  cmd_next.op = idx_ok ? OP_CLAIM_IDLE : OP_FAIL;
            KIND_FREE:        cmd_next.op = idx_ok ? OP_FREE : OP_FAIL;
            KIND_TICK:        cmd_next.op = OP_TICK;
            KIND_FIRE:        cmd_next.op = OP_FIRE;
            KIND_FREE_ALL:    cmd_next.op = OP_FREE_ALL;
            default:          cmd_next.op = OP_FAIL;
        endcase
    end

    // Valid flag of the stage.
    always_comb
    begin
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (push_ready)
        begin
            fv_next = 1'b0;
        end
        else
        begin
            fv_next = fv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    // Command payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign push_valid = fv_reg;
    assign push_data  = cmd_reg;

endmodule

>>> sv/pts_queue.sv
// Short command queue that decouples the front part from the back part.
module pts_queue
    import pts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/pts_back.sv
// Back part: executes commands against the slot table and drives results.
module pts_back
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  cmd_t      pop_data,
    pts_rsp_if.source rsp
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [NUM_SLOTS-1:0] busy_reg;
    logic [NUM_SLOTS-1:0] busy_next;
    cmd_t                 cmd_reg;
    cmd_t                 cmd_next;
    result_t              res_reg;
    result_t              res_next;
    result_t              pend_reg;
    result_t              pend_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    result_t              out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_data;
    logic                 out_load;
    logic                 out_free;

    // Slot memory: one write and one registered read per cycle.
    slot_entry_t          slot_mem [NUM_SLOTS];
    slot_entry_t          rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    slot_entry_t          mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;

    logic [IDX_W-1:0]     new_slot;
    logic                 cur_busy;
    logic                 cur_due;
    logic                 advance;

    assign out_free = !out_valid_reg || rsp.ready;
    assign new_slot = pop_data.slot[IDX_W-1:0];
    assign cur_busy = busy_reg[idx_reg];
    assign cur_due  = cur_busy && (rd_data_reg.elapsed >= {1'b0, rd_data_reg.period});

    // Command sequencer: next state, slot updates and result selection.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        busy_next       = busy_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        pop_ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;
        out_load        = 1'b0;
        out_data        = res_reg;
        advance         = 1'b1;

        case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    res_next = RES_OK;
                    case (pop_data.op)
                        OP_CLAIM_FIRST:
                        begin
                            idx_next   = '0;
                            state_next = B_CLAIM;
                        end
                        OP_OVERWRITE:
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = new_slot;
                            mem_wdata           = make_entry(pop_data);
                            busy_next[new_slot] = 1'b1;
                            res_next.slot       = 6'(new_slot);
                            state_next          = B_DONE;
                        end
                        OP_CLAIM_IDLE:
                        begin
                            if (!busy_reg[new_slot])
                            begin
                                mem_we              = 1'b1;
                                mem_waddr           = new_slot;
                                mem_wdata           = make_entry(pop_data);
                                busy_next[new_slot] = 1'b1;
                                res_next.slot       = 6'(new_slot);
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                            state_next = B_DONE;
                        end
                        OP_FREE:
                        begin
                            busy_next[new_slot] = 1'b0;
                            res_next.slot       = 6'(new_slot);
                            state_next          = B_DONE;
                        end
                        OP_TICK, OP_FIRE:
                        begin
                            mem_re          = 1'b1;
                            mem_raddr       = '0;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            state_next      = B_SCAN;
                        end
                        OP_FREE_ALL:
                        begin
                            busy_next  = '0;
                            state_next = B_DONE;
                        end
                        default:
                        begin
                            res_next.status = 1'b1;
                            state_next      = B_DONE;
                        end
                    endcase
                end
            end

            // Look for the first idle slot, one slot per cycle.
            B_CLAIM:
            begin
                if (!busy_reg[idx_reg])
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = idx_reg;
                    mem_wdata          = make_entry(cmd_reg);
                    busy_next[idx_reg] = 1'b1;
                    res_next.slot      = 6'(idx_reg);
                    state_next         = B_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_next.status = 1'b1;
                    state_next      = B_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Walk the slots for a tick or a fire; read data belongs to idx_reg.
            B_SCAN:
            begin
                if (cmd_reg.op == OP_TICK)
                begin
                    if (cur_busy && !cur_due)
                    begin
                        mem_we            = 1'b1;
                        mem_wdata.elapsed = rd_data_reg.elapsed + 17'(cmd_reg.tick);
                    end
                end
                else if (cur_due)
                begin
                    // A held report goes out before the new one replaces it.
                    if (pend_valid_reg && !out_free)
                    begin
                        advance = 1'b0;
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_data = pend_reg;
                        end
                        mem_we            = 1'b1;
                        mem_wdata.elapsed = 17'd0;
                        pend_next.status  = 1'b0;
                        pend_next.slot    = 6'(idx_reg);
                        pend_next.fired   = 1'b1;
                        pend_next.tag     = rd_data_reg.tag;
                        pend_next.arg     = rd_data_reg.arg;
                        pend_next.last    = 1'b0;
                        pend_valid_next   = 1'b1;
                    end
                end

                if (advance)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + 1'b1;
                    end
                end
            end

            // Deliver the final result of the command.
            B_DONE:
            begin
                if (cmd_reg.op == OP_FIRE && pend_valid_reg)
                begin
                    out_data      = pend_reg;
                    out_data.last = 1'b1;
                end
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    // Slot memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.result_slot    = out_reg.slot;
    assign rsp.fired          = out_reg.fired;
    assign rsp.fired_tag      = out_reg.tag;
    assign rsp.fired_argument = out_reg.arg;
    assign rsp.last           = out_reg.last;

endmodule
